// ----- sv/nth_pkg.sv -----
package nth_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = $clog2(CordicSteps);
  localparam logic signed [18:0] Pi16 = 19'sd205887;
  localparam logic signed [18:0] HalfPi16 = 19'sd102944;
  localparam logic [7:0] StateAvailable = 8'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_wr;    // write the table slot from the input transfer
    logic q_start;    // latch own position, clear the best-so-far
    logic scan_issue; // issue a table read at the scan index
    logic scan_eval;  // compare the entry held in the square registers
    logic cor_init;   // set up the CORDIC from the chosen entry
    logic cor_step;   // run one CORDIC iteration
    logic finish;     // form the result into the output register
  } nth_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index is at the last slot
    logic cor_last;   // all CORDIC iterations are done
  } nth_sts_t;

  function automatic logic signed [18:0] atan_q16(input logic [StepW-1:0] i);
    logic signed [18:0] r;
    begin
      unique case (i)
        4'd0: r = 19'sd51472;
        4'd1: r = 19'sd30385;
        4'd2: r = 19'sd16054;
        4'd3: r = 19'sd8150;
        4'd4: r = 19'sd4091;
        4'd5: r = 19'sd2047;
        4'd6: r = 19'sd1024;
        4'd7: r = 19'sd512;
        4'd8: r = 19'sd256;
        4'd9: r = 19'sd128;
        4'd10: r = 19'sd64;
        4'd11: r = 19'sd32;
        4'd12: r = 19'sd16;
        4'd13: r = 19'sd8;
        4'd14: r = 19'sd4;
        default: r = 19'sd2;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- sv/nth_ctrl.sv -----
module nth_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_mode,
  input  logic              out_busy,
  input  nth_pkg::nth_sts_t sts,
  output logic              in_ready,
  output logic              out_load,
  output nth_pkg::nth_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SETTLE = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_CORD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_load = 1'b0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_mode == nth_pkg::MODE_QUERY) begin
            cmd.q_start = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.scan_eval = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.scan_eval = 1'b1;
        state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        // last slot compared at the end of this cycle
        cmd.scan_eval = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        // read the chosen slot
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.cor_init = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.cor_last) begin
          if (!out_busy) begin
            cmd.finish = 1'b1;
            out_load = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.cor_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- sv/nth_dp.sv -----
module nth_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nth_pkg::nth_cmd_t        cmd,
  input  logic [7:0]               in_slot,
  input  logic [15:0]              in_number,
  input  logic [7:0]               in_state,
  input  logic signed [15:0]       in_x,
  input  logic signed [15:0]       in_y,
  output nth_pkg::nth_sts_t        sts,
  output logic signed [14:0]       res_heading,
  output logic                     res_found,
  output logic [15:0]              res_number
);

  localparam int unsigned SW = nth_pkg::SlotW;
  localparam int unsigned DW = nth_pkg::TableDepth;

  // number, x, y in one memory; availability flags in flops
  logic [47:0] mem [DW];
  logic        st_r [DW];
  logic [47:0] rd_r;
  logic        rd_av_r;
  logic [SW-1:0] rd_idx_r;

  logic [SW:0] scan_r;
  logic        ev_r;
  logic signed [15:0] own_x_r, own_y_r;
  logic        have_r;
  logic [33:0] best_d_r;
  logic [SW-1:0] best_r;

  logic [SW-1:0] rd_addr;
  logic signed [16:0] dx, dy;
  logic [33:0] sq_dist;

  always_comb begin
    rd_addr = cmd.scan_issue ? scan_r[SW-1:0] : best_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && ({8'd0, in_slot} < 16'(DW)))
      mem[in_slot[SW-1:0]] <= {in_y, in_x, in_number};
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DW; i++) st_r[i] <= 1'b0;
    end else if (cmd.load_wr && ({8'd0, in_slot} < 16'(DW))) begin
      st_r[in_slot[SW-1:0]] <= (in_state == nth_pkg::StateAvailable);
    end
  end

  always_ff @(posedge clk) begin
    rd_av_r <= st_r[rd_addr];
    rd_idx_r <= rd_addr;
    ev_r <= cmd.scan_issue;
  end

  assign dx = 17'(signed'(rd_r[31:16])) - 17'(own_x_r);
  assign dy = 17'(signed'(rd_r[47:32])) - 17'(own_y_r);
  // squares registered separately to keep one multiplier per path
  logic signed [33:0] dx_sq, dy_sq;
  logic [33:0] sqx_r, sqy_r;
  logic        sq_v_r, sq_av_r;
  logic [SW-1:0] sq_idx_r;
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  always_ff @(posedge clk) begin
    sqx_r <= unsigned'(dx_sq);
    sqy_r <= unsigned'(dy_sq);
    sq_v_r <= ev_r;
    sq_av_r <= rd_av_r;
    sq_idx_r <= rd_idx_r;
  end
  assign sq_dist = sqx_r + sqy_r;

  assign sts.scan_last = (scan_r[SW-1:0] == SW'(DW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      have_r <= 1'b0;
    end else if (cmd.q_start) begin
      scan_r <= '0;
      have_r <= 1'b0;
      own_x_r <= in_x;
      own_y_r <= in_y;
    end else begin
      if (cmd.scan_issue) scan_r <= scan_r + 1'b1;
      if (cmd.scan_eval && sq_v_r && sq_av_r && (!have_r || sq_dist < best_d_r)) begin
        have_r <= 1'b1;
        best_d_r <= sq_dist;
        best_r <= sq_idx_r;
      end
    end
  end

  // CORDIC on |dx|,|dy| of the chosen slot (rd_r holds it during cor_init)
  logic signed [31:0] cx_r, cy_r;
  logic signed [18:0] cz_r;
  logic [nth_pkg::StepW:0] it_r;
  logic        neg_x_r, neg_y_r, ay0_r, ax0_r;
  logic [15:0] num_r;
  logic [16:0] ax, ay;
  logic signed [31:0] xs, ys;
  logic signed [18:0] za, a;
  logic signed [19:0] hr;

  assign ax = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay = dy[16] ? 17'(-dy) : 17'(dy);
  assign xs = cx_r >>> it_r[nth_pkg::StepW-1:0];
  assign ys = cy_r >>> it_r[nth_pkg::StepW-1:0];
  assign sts.cor_last = it_r[nth_pkg::StepW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else if (cmd.cor_init) begin
      cx_r <= 32'({ax, 12'd0});
      cy_r <= 32'({ay, 12'd0});
      cz_r <= '0;
      // skip the iterations when nothing was found or the target lies on an axis
      it_r <= (!have_r || ax == 17'd0 || ay == 17'd0) ?
              {1'b1, {nth_pkg::StepW{1'b0}}} : '0;
      neg_x_r <= dx[16];
      neg_y_r <= dy[16];
      ay0_r <= (ay == 17'd0);
      ax0_r <= (ax == 17'd0);
      num_r <= rd_r[15:0];
    end else if (cmd.cor_step) begin
      if (!cy_r[31]) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + nth_pkg::atan_q16(it_r[nth_pkg::StepW-1:0]);
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - nth_pkg::atan_q16(it_r[nth_pkg::StepW-1:0]);
      end
      it_r <= it_r + 1'b1;
    end
  end

  always_comb begin
    if (ay0_r) za = '0;
    else if (ax0_r) za = nth_pkg::HalfPi16;
    else if (cz_r < 0) za = '0;
    else if (cz_r > nth_pkg::HalfPi16) za = nth_pkg::HalfPi16;
    else za = cz_r;
    a = neg_x_r ? nth_pkg::Pi16 - za : za;
    hr = (20'(a) + 20'sd8) >>> 4;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_found <= have_r;
      res_number <= have_r ? num_r : 16'd0;
      res_heading <= !have_r ? 15'sd0 : (neg_y_r ? 15'(-hr) : 15'(hr));
    end
  end

endmodule

// ----- sv/nearest_target_heading.sv -----
// Channel | Direction | tdata fields (low bit up)                       | tuser
// in_     | slave     | slot, target_number, target_state, pos_x, pos_y | mode
// out_    | master    | heading, nearest_number                         | found
//
// A load transfer writes one table slot in its accept cycle; the next item may follow at once.
// After a query transfer in_tready stays low while the block makes one table read per slot,
// drains the read and compare pipeline (DRAIN, SETTLE), fetches the chosen slot (FETCH),
// sets up the CORDIC, runs 16 iterations and loads the result (iterations skipped when nothing
// is found or the target lies on an axis). Reset clears the slot availability flags at once;
// number and coordinates are not reset. The result step stalls while an untaken result waits.
module nearest_target_heading (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // slot, target_number, target_state, pos_x, pos_y
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // heading[14:0], nearest_number[30:15], zero
  output logic        out_tuser   // found
);

  nth_pkg::nth_cmd_t cmd;
  nth_pkg::nth_sts_t sts;
  logic in_fire, out_load, out_busy;
  logic signed [14:0] res_heading;
  logic res_found;
  logic [15:0] res_number;

  assign in_fire = in_tvalid && in_tready;
  // the output register can be loaded when empty or being drained
  assign out_busy = out_tvalid && !out_tready;

  nth_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_mode(in_tuser),
    .out_busy(out_busy), .sts(sts), .in_ready(in_tready),
    .out_load(out_load), .cmd(cmd)
  );

  nth_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_slot(in_tdata[7:0]), .in_number(in_tdata[23:8]),
    .in_state(in_tdata[31:24]), .in_x(in_tdata[47:32]), .in_y(in_tdata[63:48]),
    .sts(sts), .res_heading(res_heading), .res_found(res_found),
    .res_number(res_number)
  );

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, res_number, res_heading};
  assign out_tuser = res_found;

`ifndef SYNTH
  // never load a new result over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_tvalid && !out_tready))
    else $error("result overwritten");
  // no result when nothing was found carries a number
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[30:0] == 31'd0))
    else $error("empty result not zero");
  // a load of the output register is always followed by a valid result
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("result lost");
`endif

endmodule
